/* sv/ptpu_pkg.sv */
package ptpu_pkg;

   // fixed field widths
   localparam int BYTE_W      = 8;
   localparam int RI_W        = 20;
   localparam int DIM_CFG_W   = 11;
   localparam int TILE_CFG_W  = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 11;

   // default geometry limits
   localparam int DEF_MAX_DIM  = 1024;
   localparam int DEF_MAX_TILE = 64;

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;

   // register reset values
   localparam logic [1:0]            RST_DEPTH  = 2'd2;
   localparam logic                  RST_KEEP   = 1'b0;
   localparam logic [DIM_CFG_W-1:0]  RST_WIDTH  = 11'd256;
   localparam logic [DIM_CFG_W-1:0]  RST_HEIGHT = 11'd256;
   localparam logic [TILE_CFG_W-1:0] RST_TILE_W = 7'd8;
   localparam logic [TILE_CFG_W-1:0] RST_TILE_H = 7'd8;

   localparam logic [1:0] DEPTH_8BPP = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH    = 3'd0,
      CSR_KEEP     = 3'd1,
      CSR_WIDTH    = 3'd2,
      CSR_HEIGHT   = 3'd3,
      CSR_TILE_W   = 3'd4,
      CSR_TILE_H   = 3'd5
   } csr_index_type;

   // one queued item: byte already in unpack order, plus its depth
   typedef struct packed {
      logic [BYTE_W-1:0] bits;
      logic [1:0]        depth;
   } qentry_type;

   function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[BYTE_W-1-i] = b[i];
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] pixel_mask(input logic [1:0] depth);
      logic [BYTE_W-1:0] m;
      unique case (depth)
         2'd0: m = 8'h01;
         2'd1: m = 8'h03;
         2'd2: m = 8'h0F;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   // index of the final pixel within a byte
   function automatic logic [2:0] last_slot(input logic [1:0] depth);
      logic [2:0] s;
      unique case (depth)
         2'd0: s = 3'd7;
         2'd1: s = 3'd3;
         2'd2: s = 3'd1;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

endpackage

/* sv/ptpu_front.sv */
module ptpu_front import ptpu_pkg::*; (
   input  logic              req_valid,
   input  logic [BYTE_W-1:0] req_packed_byte,
   output logic              req_stall,
   input  logic [1:0]        depth_code,
   input  logic              keep_bit_order,
   input  logic              q_full,
   input  logic              hold,
   output logic              push,
   output qentry_type        push_entry
);

   // accept when the queue has room, geometry is settled and no register write is offered
   assign req_stall = q_full || hold;
   assign push      = req_valid && !req_stall;

   // put the byte in unpack order: reversed below 8 bpp unless kept
   always_comb begin
      push_entry.depth = depth_code;
      if (depth_code != DEPTH_8BPP && !keep_bit_order) begin
         push_entry.bits = flip8(req_packed_byte);
      end else begin
         push_entry.bits = req_packed_byte;
      end
   end

endmodule

/* sv/ptpu_fifo.sv */
module ptpu_fifo import ptpu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   input  logic       pop,
   output qentry_type head,
   output logic       empty,
   output logic       full
);

   qentry_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]       count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");

endmodule

/* sv/ptpu_div.sv */
module ptpu_div #(
   parameter int DIM_W  = 11,
   parameter int TILE_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIM_W-1:0]  dividend_x,
   input  logic [DIM_W-1:0]  dividend_y,
   input  logic [TILE_W-1:0] divisor_x,
   input  logic [TILE_W-1:0] divisor_y,
   output logic              busy,
   output logic [DIM_W-1:0]  quot_x,
   output logic [DIM_W-1:0]  quot_y
);

   localparam int SC_W = $clog2(DIM_W + 1);
   localparam int TW1  = TILE_W + 1;

   logic [DIM_W-1:0]  dvd [2];
   logic [TILE_W-1:0] dvs [2];
   logic [DIM_W-1:0]  quo_ff [2];
   logic [DIM_W-1:0]  quo_in [2];
   logic [TILE_W-1:0] rem_ff [2];
   logic [TILE_W-1:0] rem_in [2];
   logic [TW1-1:0]    trial [2];
   logic [TW1-1:0]    diff [2];
   logic              ge [2];
   logic              busy_ff, busy_in;
   logic [SC_W-1:0]   cnt_ff, cnt_in;

   assign dvd[0] = dividend_x;
   assign dvd[1] = dividend_y;
   assign dvs[0] = divisor_x;
   assign dvs[1] = divisor_y;
   assign busy   = busy_ff;

   // tile counts: a zero quotient counts as one tile
   assign quot_x = (quo_ff[0] == '0) ? DIM_W'(1) : quo_ff[0];
   assign quot_y = (quo_ff[1] == '0) ? DIM_W'(1) : quo_ff[1];

   // restoring division, one quotient bit per cycle while busy, both lanes together
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         trial[i]  = {rem_ff[i], quo_ff[i][DIM_W-1]};
         diff[i]   = trial[i] - TW1'(dvs[i]);
         ge[i]     = (trial[i] >= TW1'(dvs[i]));
         quo_in[i] = quo_ff[i];
         rem_in[i] = rem_ff[i];
         if (start) begin
            quo_in[i] = dvd[i];
            rem_in[i] = '0;
         end else if (busy_ff) begin
            quo_in[i] = {quo_ff[i][DIM_W-2:0], ge[i]};
            rem_in[i] = ge[i] ? diff[i][TILE_W-1:0] : trial[i][TILE_W-1:0];
         end
      end
   end

   // step counter
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = SC_W'(DIM_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SC_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         quo_ff[i] <= quo_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

endmodule

/* sv/ptpu_back.sv */
module ptpu_back import ptpu_pkg::*; #(
   parameter int DIM_W  = 11,
   parameter int TILE_W = 7,
   parameter int TC_W   = 10,
   parameter int CT_W   = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  qentry_type        q_head,
   output logic              q_pop,
   input  logic              geom_ok,
   input  logic [DIM_W-1:0]  width,
   input  logic [TILE_W-1:0] tile_w,
   input  logic [TILE_W-1:0] tile_h,
   input  logic [DIM_W-1:0]  tiles_x,
   input  logic [DIM_W-1:0]  tiles_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_pixel_value,
   output logic [RI_W-1:0]   rsp_raster_index,
   output logic              rsp_last_of_byte,
   output logic              rsp_last_of_frame
);

   localparam int TW1 = TILE_W + 1;
   localparam int DW1 = DIM_W + 1;

   logic              adv, issue, at_last;
   logic [2:0]        k_ff, k_in;
   logic [2:0]        shamt;
   logic [BYTE_W-1:0] shifted, pix;
   logic              wc, wtc, wl, wr, lof;

   logic [CT_W-1:0]   col_ff, col_in;
   logic [CT_W-1:0]   line_ff, line_in;
   logic [TC_W-1:0]   tcol_ff, tcol_in;
   logic [TC_W-1:0]   trow_ff, trow_in;

   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_pix_ff;
   logic              s1_lob_ff, s1_lof_ff;
   logic [RI_W-1:0]   s1_row_ff, s1_row_in;
   logic [RI_W-1:0]   s1_col_ff, s1_col_in;

   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_pix_ff;
   logic [RI_W-1:0]   out_idx_ff, out_idx_in;
   logic              out_lob_ff, out_lof_ff;

   // whole pipe moves unless the output register is held
   assign adv     = !out_valid_ff || !rsp_stall;
   assign issue   = adv && q_valid && geom_ok;
   assign at_last = (k_ff == last_slot(q_head.depth));
   assign q_pop   = issue && at_last;

   // pick the current pixel from the head byte
   always_comb begin
      shamt   = 3'(k_ff << q_head.depth);
      shifted = q_head.bits >> shamt;
      pix     = shifted & pixel_mask(q_head.depth);
      k_in    = k_ff;
      if (issue) begin
         k_in = at_last ? 3'd0 : k_ff + 3'd1;
      end
   end

   // wrap conditions of the position counters
   always_comb begin
      wc  = (TW1'(col_ff)  + TW1'(1) >= TW1'(tile_w));
      wtc = (DW1'(tcol_ff) + DW1'(1) >= DW1'(tiles_x));
      wl  = (TW1'(line_ff) + TW1'(1) >= TW1'(tile_h));
      wr  = (DW1'(trow_ff) + DW1'(1) >= DW1'(tiles_y));
      lof = wc && wtc && wl && wr;
   end

   // counter advance: column, tile column, line, tile row
   always_comb begin
      col_in  = col_ff;
      tcol_in = tcol_ff;
      line_in = line_ff;
      trow_in = trow_ff;
      if (issue) begin
         col_in = wc ? '0 : col_ff + 1'b1;
         if (wc) begin
            tcol_in = wtc ? '0 : tcol_ff + 1'b1;
            if (wtc) begin
               line_in = wl ? '0 : line_ff + 1'b1;
               if (wl) begin
                  trow_in = wr ? '0 : trow_ff + 1'b1;
               end
            end
         end
      end
   end

   // raster position, low bits only
   always_comb begin
      s1_row_in  = RI_W'(trow_ff) * RI_W'(tile_h) + RI_W'(line_ff);
      s1_col_in  = RI_W'(tcol_ff) * RI_W'(tile_w) + RI_W'(col_ff);
      out_idx_in = s1_row_ff * RI_W'(width) + s1_col_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         col_ff       <= '0;
         line_ff      <= '0;
         tcol_ff      <= '0;
         trow_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff    <= k_in;
         col_ff  <= col_in;
         line_ff <= line_in;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
         if (adv) begin
            s1_valid_ff  <= issue;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_pix_ff <= pix;
         s1_lob_ff <= at_last;
         s1_lof_ff <= lof;
         s1_row_ff <= s1_row_in;
         s1_col_ff <= s1_col_in;
      end
      if (adv && s1_valid_ff) begin
         out_pix_ff <= s1_pix_ff;
         out_idx_ff <= out_idx_in;
         out_lob_ff <= s1_lob_ff;
         out_lof_ff <= s1_lof_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_value   = out_pix_ff;
   assign rsp_raster_index  = out_idx_ff;
   assign rsp_last_of_byte  = out_lob_ff;
   assign rsp_last_of_frame = out_lof_ff;

   a_slot_restart: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (k_ff == 3'd0)) else $error("pixel slot not restarted");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> s1_valid_ff) else $error("pixel lost in pipe");

endmodule

/* sv/packed_tile_pixel_unpacker.sv */
// Tiled packed-pixel to linear 8-bit pixel unpacker.
//
// Input channel (req_*): one raw image byte per item, in tiled storage order
// (tile rows, lines in a tile, tile columns, columns in a line). Output
// channel (rsp_*): one item per pixel with its value, row-major raster index
// and last-of-byte / last-of-frame flags. Both channels use valid/stall.
// Configuration (csr_*): index/data writes, taken while csr_ready is high.
//
// A byte yields 8 >> depth_code pixels, one per cycle while rsp_stall does not
// hold the output and the geometry is settled; the single pixel issue slot of
// the back end sets this rate. Each pixel passes the back end's s1 register and
// then its output register. A 4-entry queue separates byte intake from pixel
// issue, so input is taken while results are waiting.
// After reset and after every register write the tile counts are recomputed
// by a bit-serial divider: input is stalled while the divide is pending or
// running and while csr_valid is high, and csr_ready is low while the divider
// is busy. Reset clears the position counters and loads the register defaults.
// When rsp_stall is high and an output item is valid, it holds and the whole
// pixel pipe freezes; input continues until the queue fills.
module packed_tile_pixel_unpacker import ptpu_pkg::*; #(
   parameter int MAX_DIM  = DEF_MAX_DIM,
   parameter int MAX_TILE = DEF_MAX_TILE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_packed_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_pixel_value,
   output logic [RI_W-1:0]       rsp_raster_index,
   output logic                  rsp_last_of_byte,
   output logic                  rsp_last_of_frame,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int TILE_W = $clog2(MAX_TILE + 1);
   localparam int TC_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CT_W   = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;

   logic [1:0]            depth_ff;
   logic                  keep_ff;
   logic [DIM_CFG_W-1:0]  width_ff, height_ff;
   logic [TILE_CFG_W-1:0] tile_w_ff, tile_h_ff;
   logic                  dirty_ff, dirty_in;

   logic                  csr_write, div_start, div_busy, hold, geom_ok;
   logic [DIM_W-1:0]      w_cl, h_cl, tiles_x, tiles_y;
   logic [TILE_W-1:0]     tw_cl, th_cl;

   logic                  push, pop, q_empty, q_full;
   qentry_type            push_entry, q_head;

   assign csr_ready = !div_busy;
   assign csr_write = csr_valid && csr_ready;
   assign div_start = dirty_ff && !div_busy;
   assign hold      = dirty_ff || div_busy || csr_valid;
   assign geom_ok   = !dirty_ff && !div_busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= RST_DEPTH;
         keep_ff   <= RST_KEEP;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         tile_w_ff <= RST_TILE_W;
         tile_h_ff <= RST_TILE_H;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEPTH:  depth_ff  <= csr_data[1:0];
            CSR_KEEP:   keep_ff   <= csr_data[0];
            CSR_WIDTH:  width_ff  <= csr_data[DIM_CFG_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[DIM_CFG_W-1:0];
            CSR_TILE_W: tile_w_ff <= csr_data[TILE_CFG_W-1:0];
            CSR_TILE_H: tile_h_ff <= csr_data[TILE_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // tile counts need recomputing after reset and after any write
   always_comb begin
      dirty_in = dirty_ff;
      if (csr_write) begin
         dirty_in = 1'b1;
      end else if (div_start) begin
         dirty_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b1;
      end else begin
         dirty_ff <= dirty_in;
      end
   end

   // clamp dimensions to [1, limit]
   always_comb begin
      if (width_ff == '0) begin
         w_cl = DIM_W'(1);
      end else if (32'(width_ff) > MAX_DIM) begin
         w_cl = DIM_W'(MAX_DIM);
      end else begin
         w_cl = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_cl = DIM_W'(1);
      end else if (32'(height_ff) > MAX_DIM) begin
         h_cl = DIM_W'(MAX_DIM);
      end else begin
         h_cl = DIM_W'(height_ff);
      end
      if (tile_w_ff == '0) begin
         tw_cl = TILE_W'(1);
      end else if (32'(tile_w_ff) > MAX_TILE) begin
         tw_cl = TILE_W'(MAX_TILE);
      end else begin
         tw_cl = TILE_W'(tile_w_ff);
      end
      if (tile_h_ff == '0) begin
         th_cl = TILE_W'(1);
      end else if (32'(tile_h_ff) > MAX_TILE) begin
         th_cl = TILE_W'(MAX_TILE);
      end else begin
         th_cl = TILE_W'(tile_h_ff);
      end
   end

   ptpu_div #(
      .DIM_W  (DIM_W),
      .TILE_W (TILE_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (w_cl),
      .dividend_y (h_cl),
      .divisor_x  (tw_cl),
      .divisor_y  (th_cl),
      .busy       (div_busy),
      .quot_x     (tiles_x),
      .quot_y     (tiles_y)
   );

   ptpu_front u_front (
      .req_valid       (req_valid),
      .req_packed_byte (req_packed_byte),
      .req_stall       (req_stall),
      .depth_code      (depth_ff),
      .keep_bit_order  (keep_ff),
      .q_full          (q_full),
      .hold            (hold),
      .push            (push),
      .push_entry      (push_entry)
   );

   ptpu_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   ptpu_back #(
      .DIM_W  (DIM_W),
      .TILE_W (TILE_W),
      .TC_W   (TC_W),
      .CT_W   (CT_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (!q_empty),
      .q_head            (q_head),
      .q_pop             (pop),
      .geom_ok           (geom_ok),
      .width             (w_cl),
      .tile_w            (tw_cl),
      .tile_h            (th_cl),
      .tiles_x           (tiles_x),
      .tiles_y           (tiles_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_raster_index  (rsp_raster_index),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   a_hold_while_div: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (req_stall && !pop)) else $error("item moved during divide");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import ptpu_pkg::*;

   localparam logic [1:0] DEPTH_1BPP = 2'd0;
   localparam logic [1:0] DEPTH_2BPP = 2'd1;
   localparam logic [1:0] DEPTH_4BPP = 2'd2;

   // one expected pixel item
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic [RI_W-1:0]   raster_index;
      logic              last_of_byte;
      logic              last_of_frame;
   } pixel_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_packed_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_pixel_value;
   logic [RI_W-1:0]       rsp_raster_index;
   logic                  rsp_last_of_byte;
   logic                  rsp_last_of_frame;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow registers and position counters
   logic [1:0]            cfg_depth  = RST_DEPTH;
   logic                  cfg_keep   = RST_KEEP;
   logic [DIM_CFG_W-1:0]  cfg_width  = RST_WIDTH;
   logic [DIM_CFG_W-1:0]  cfg_height = RST_HEIGHT;
   logic [TILE_CFG_W-1:0] cfg_tile_w = RST_TILE_W;
   logic [TILE_CFG_W-1:0] cfg_tile_h = RST_TILE_H;
   logic [5:0]            col_in_tile  = '0;
   logic [5:0]            line_in_tile = '0;
   logic [9:0]            tile_col     = '0;
   logic [9:0]            tile_row     = '0;

   pixel_type expected_pixels[$];
   bit     quiet_tail = 1'b0;
   int     failures = 0;
   int     bytes_sent = 0;
   int     pixels_checked = 0;
   int     frame_ends = 0;
   int     reg_writes = 0;

   packed_tile_pixel_unpacker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_packed_byte   (req_packed_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_raster_index  (rsp_raster_index),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int clamp_to(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // unpack one byte into pixels and advance the tile position counters
   function automatic void predict_pixels(input logic [BYTE_W-1:0] raw);
      int w, h, tw, th, tiles_x, tiles_y, bpp, count, row, col, idx;
      logic [BYTE_W-1:0] bits;
      pixel_type px;
      w  = clamp_to(cfg_width, DEF_MAX_DIM);
      h  = clamp_to(cfg_height, DEF_MAX_DIM);
      tw = clamp_to(cfg_tile_w, DEF_MAX_TILE);
      th = clamp_to(cfg_tile_h, DEF_MAX_TILE);
      tiles_x = w / tw;
      tiles_y = h / th;
      if (tiles_x == 0) tiles_x = 1;
      if (tiles_y == 0) tiles_y = 1;
      bpp   = 1 << cfg_depth;
      count = 8 / bpp;
      bits  = raw;
      // bit reversal below 8 bpp unless the byte order is kept
      if (cfg_depth != DEPTH_8BPP && !cfg_keep)
         for (int i = 0; i < BYTE_W; i++) bits[i] = raw[BYTE_W-1-i];
      for (int k = 0; k < count; k++) begin
         row = tile_row * th + line_in_tile;
         col = tile_col * tw + col_in_tile;
         idx = row * w + col;
         px.value         = (bits >> (bpp * k)) & ((1 << bpp) - 1);
         px.raster_index  = idx[RI_W-1:0];
         px.last_of_byte  = (k + 1 == count);
         px.last_of_frame = (col_in_tile + 1 >= tw) && (line_in_tile + 1 >= th) &&
                            (tile_col + 1 >= tiles_x) && (tile_row + 1 >= tiles_y);
         expected_pixels.push_back(px);
         // column, then tile column, then line, then tile row; wrap at or past limit
         if (col_in_tile + 1 >= tw) begin
            col_in_tile = '0;
            if (tile_col + 1 >= tiles_x) begin
               tile_col = '0;
               if (line_in_tile + 1 >= th) begin
                  line_in_tile = '0;
                  if (tile_row + 1 >= tiles_y) tile_row = '0;
                  else tile_row = tile_row + 1'b1;
               end else begin
                  line_in_tile = line_in_tile + 1'b1;
               end
            end else begin
               tile_col = tile_col + 1'b1;
            end
         end else begin
            col_in_tile = col_in_tile + 1'b1;
         end
      end
   endfunction

   // send one byte item, with an occasional gap before it
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_packed_byte <= value;
      do @(posedge clock); while (req_stall);
      predict_pixels(value);
      bytes_sent++;
   endtask

   // stop sending and wait for every pending pixel
   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write; csr_valid is left high for a following write
   task automatic write_reg(input csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEPTH:  cfg_depth  = value[1:0];
         CSR_KEEP:   cfg_keep   = value[0];
         CSR_WIDTH:  cfg_width  = value[DIM_CFG_W-1:0];
         CSR_HEIGHT: cfg_height = value[DIM_CFG_W-1:0];
         CSR_TILE_W: cfg_tile_w = value[TILE_CFG_W-1:0];
         CSR_TILE_H: cfg_tile_h = value[TILE_CFG_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // program all registers while the block is idle
   task automatic configure(input logic [1:0] depth, input logic keep,
                            input int w, input int h, input int tw, input int th);
      drain_pixels();
      write_reg(CSR_DEPTH, depth);
      write_reg(CSR_KEEP, keep);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_TILE_W, tw);
      write_reg(CSR_TILE_H, th);
      csr_valid <= 1'b0;
   endtask

   // pixel checker
   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel item: value %0h index %0d", rsp_pixel_value,
                   rsp_raster_index);
            failures++;
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_last_of_frame) frame_ends++;
            if (rsp_pixel_value !== want.value) begin
               $error("pixel_value: expected %0h, got %0h", want.value, rsp_pixel_value);
               failures++;
            end
            if (rsp_raster_index !== want.raster_index) begin
               $error("raster_index: expected %0d, got %0d", want.raster_index,
                      rsp_raster_index);
               failures++;
            end
            if (rsp_last_of_byte !== want.last_of_byte) begin
               $error("last_of_byte: expected %0b, got %0b", want.last_of_byte,
                      rsp_last_of_byte);
               failures++;
            end
            if (rsp_last_of_frame !== want.last_of_frame) begin
               $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                      rsp_last_of_frame);
               failures++;
            end
         end
      end
   end

   // output back-pressure in random bursts
   initial begin : stall_driver
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // register defaults straight out of reset
   task automatic test_reset_defaults();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);
   endtask

   // every depth with and without bit reversal
   task automatic test_depths_and_order();
      logic [BYTE_W-1:0] patterns [8] = '{8'h01, 8'h80, 8'h1E, 8'hC3,
                                          8'h7F, 8'hFE, 8'h55, 8'hAA};
      logic [1:0] depth;
      for (int n = 0; n < 8; n++) begin
         depth = n[2:1];
         configure(depth, n[0], 8, 2, 4, 2);
         send_byte(patterns[n]);
      end
   endtask

   // a byte per frame so the counters wrap on every byte
   task automatic test_frame_wrap();
      configure(DEPTH_1BPP, 1'b0, 4, 2, 2, 1);
      send_byte(8'h96);
      send_byte(8'h3C);
      send_byte(8'hF0);
   endtask

   // zero, oversized, tile wider than image, image not a tile multiple
   task automatic test_dimension_clamps();
      configure(DEPTH_2BPP, 1'b1, 0, 0, 0, 0);
      send_byte(8'hE4);
      configure(DEPTH_1BPP, 1'b0, 2047, 2047, 127, 127);
      send_byte(8'h5A);
      configure(DEPTH_1BPP, 1'b1, 3, 2, 8, 4);
      send_byte(8'hC6);
      configure(DEPTH_4BPP, 1'b0, 10, 5, 4, 2);
      send_byte(8'h3E);
      send_byte(8'h81);
   endtask

   // shrink the geometry with the counters partway through a frame
   task automatic test_midframe_change();
      configure(DEPTH_8BPP, 1'b0, 16, 16, 8, 8);
      repeat (4) send_byte($urandom_range(0, 255));
      configure(DEPTH_8BPP, 1'b0, 4, 16, 2, 2);
      repeat (2) send_byte($urandom_range(0, 255));
   endtask

   // walk the tile row counter far down, then widen to reach high raster indices
   task automatic test_deep_raster();
      logic keep;
      keep = $urandom_range(0, 1);
      configure(DEPTH_1BPP, keep, 1, 1024, 1, 1);
      repeat (64) send_byte($urandom_range(0, 255));
      configure(DEPTH_1BPP, keep, 1024, 1024, 1, 1);
      repeat (2) send_byte($urandom_range(0, 255));
   endtask

   // random small geometries, roughly a frame or more per setting
   task automatic test_random_frames();
      int sent, tw, th, w, h, n, ppb;
      logic [1:0] depth;
      logic [BYTE_W-1:0] value;
      sent = 0;
      while (sent < 38) begin
         depth = $urandom_range(0, 3);
         tw = $urandom_range(1, 5);
         th = $urandom_range(1, 3);
         w  = tw * $urandom_range(1, 3);
         h  = th * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) w = w + $urandom_range(0, tw - 1);
         if ($urandom_range(0, 3) == 0) h = h + $urandom_range(0, th - 1);
         ppb = 8 >> depth;
         n = ((w / tw) * tw * (h / th) * th + ppb - 1) / ppb + $urandom_range(0, 3);
         // now and then an out-of-range geometry
         if ($urandom_range(0, 7) == 0) begin
            w  = $urandom_range(0, 2047);
            h  = $urandom_range(0, 2047);
            tw = $urandom_range(0, 127);
            th = $urandom_range(0, 127);
            n  = $urandom_range(2, 6);
         end
         if (n > 16) n = 16;
         configure(depth, $urandom_range(0, 1), w, h, tw, th);
         repeat (n) begin
            if (sent >= 26) quiet_tail = 1'b1;
            case ($urandom_range(0, 7))
               0:       value = 8'h00;
               1:       value = 8'hFF;
               default: value = $urandom_range(0, 255);
            endcase
            send_byte(value);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_depths_and_order();
      test_frame_wrap();
      test_dimension_clamps();
      test_midframe_change();
      test_deep_raster();
      test_random_frames();
      drain_pixels();
      repeat (16) @(posedge clock);
      $display("Checked %0d pixels from %0d bytes, %0d frame ends, %0d register writes.",
               pixels_checked, bytes_sent, frame_ends, reg_writes);
      $display("Ran all depths, both bit orders, clamped and partial geometry, %s",
               "mid-frame changes and high raster indices.");
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(5_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
